[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define MMX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also runs during reset
`define MMX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mmx_pkg.sv]
`timescale 1ns / 1ps
package mmx_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 31;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;

    // Action codes
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] low_value;
        logic [VALUE_BITS-1:0] high_value;
        logic [VALUE_BITS-1:0] spread;
        logic [CNT_W-1:0]      item_total;
    } mmx_result_t;

    // Ring address: (a + b) mod CAPACITY, both operands below CAPACITY
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

[rtl/mmx_ram.sv]
`timescale 1ns / 1ps
module mmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/mmx_ctrl.sv]
`timescale 1ns / 1ps
module mmx_ctrl
    import mmx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_action,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mmx_result_t           res,
    output logic [CNT_W-1:0]      count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PUTV  = 3'd2;
    localparam logic [2:0] S_EXLO  = 3'd3;
    localparam logic [2:0] S_EXHI  = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] lo_reg, lo_next;
    mmx_result_t           res_reg, res_next;

    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_data, rd_data;
    logic [ADDR_W-1:0]     last_off;

    // Sorted ring: entry base is the minimum, base+count-1 the maximum
    mmx_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_off  = ADDR_W'(count_reg - CNT_W'(1));
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RES);
    assign res       = res_reg;
    assign count     = count_reg;

    // Sequencer: insertion shifts one entry per cycle, extract reads both ends
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = ring_add(base_reg, pos_reg);
        wr_data    = val_reg;
        rd_en      = 1'b0;
        rd_addr    = base_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next = '0;
                    res_next.item_total = count_reg;
                    if (in_action == ACT_INSERT) begin
                        val_next = in_value;
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            res_next.status = ST_FULL;
                            state_next = S_RES;
                        end else if (count_reg == '0) begin
                            pos_next   = '0;
                            state_next = S_PUTV;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = ring_add(base_reg, last_off);
                            pos_next   = ADDR_W'(count_reg);
                            state_next = S_SHIFT;
                        end
                    end else begin
                        if (count_reg < CNT_W'(2)) begin
                            res_next.status = ST_FEW;
                            state_next = S_RES;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = base_reg;
                            state_next = S_EXLO;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // rd_data holds entry pos-1
                wr_en = 1'b1;
                if (rd_data > val_reg) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = S_PUTV;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ring_add(base_reg, pos_reg - ADDR_W'(2));
                    end
                end else begin
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    res_next.item_total = count_reg + CNT_W'(1);
                    state_next = S_RES;
                end
            end
            S_PUTV: begin
                wr_en      = 1'b1;
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
                res_next.item_total = count_reg + CNT_W'(1);
                state_next = S_RES;
            end
            S_EXLO: begin
                lo_next    = rd_data;
                rd_en      = 1'b1;
                rd_addr    = ring_add(base_reg, last_off);
                state_next = S_EXHI;
            end
            S_EXHI: begin
                res_next.status     = ST_OK;
                res_next.low_value  = lo_reg;
                res_next.high_value = rd_data;
                res_next.spread     = rd_data - lo_reg;
                res_next.item_total = count_reg - CNT_W'(2);
                count_next = count_reg - CNT_W'(2);
                base_next  = ring_add(base_reg, ADDR_W'(1));
                state_next = S_RES;
            end
            S_RES: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            base_reg  <= base_next;
        end
        pos_reg <= pos_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        res_reg <= res_next;
    end

endmodule

[rtl/min_max_multiset_extract_core.sv]
// An insert moves each held value above the new one (k, up to CAPACITY - 1) up one slot
// in the sorted ring memory, then writes the new value; an extract makes two memory reads
// (minimum, then maximum); full or too-few results leave the memory untouched. Every result
// passes through the output register and may wait there on m_tready.
// Throughput: one beat at a time; s_tready stays low until the result reaches that register.
// Reset (aresetn low, synchronous) empties the store; memory contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module min_max_multiset_extract_core
    import mmx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [30:0] new_value, [31] zero pad
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [30:0] low_value, [61:31] high_value,
                                    // [92:62] spread, [103:93] item_total
    output logic [1:0]   m_tuser    // [1:0] status
);

    logic             res_valid, res_ready;
    mmx_result_t      res;
    logic [CNT_W-1:0] count;
    logic             m_valid_reg;
    mmx_result_t      m_res_reg;

    mmx_ctrl u_ctrl (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count)
    );

    // Output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {m_res_reg.item_total, m_res_reg.spread,
                       m_res_reg.high_value, m_res_reg.low_value};

    `MMX_ASSERT(a_count_range, aclk, aresetn, count <= CNT_W'(CAPACITY), "count over capacity")
    `MMX_ASSERT(a_full_total, aclk, aresetn, (m_tvalid && m_tuser == ST_FULL) |-> (m_res_reg.item_total == CNT_W'(CAPACITY)), "full result with room left")
    `MMX_ASSERT(a_few_total, aclk, aresetn, (m_tvalid && m_tuser == ST_FEW) |-> (m_res_reg.item_total < CNT_W'(2)), "too-few result with two or more held")
    `MMX_ASSERT(a_order, aclk, aresetn, (m_tvalid && m_tuser == ST_OK) |-> (m_res_reg.low_value <= m_res_reg.high_value), "extract low above high")

endmodule
